FILE: design/ksp_pkg.sv
// ksp_pkg: shared widths, codes, command and status structs, fixed-point helpers
// and the cosine table generator for the kinetic scroll position engine.
// No dependencies; every design file imports it.
package ksp_pkg;

    localparam int HEAD_W    = 24;
    localparam int VAL_W     = 24;
    localparam int CFG_W     = 23;
    localparam int OP_W      = 3;
    localparam int CODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 4;
    localparam int WIDE_W    = HEAD_W + 2;

    localparam int FRAC_BITS         = 8;
    localparam int MOVE_STEPS        = 12;
    localparam int COS_DEPTH_DEFAULT = 64;
    localparam int COS_W             = 16;
    localparam int COS_FRAC          = 14;
    localparam longint COS_STEP_Q30  = 64'sd1025784744;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // motion stops once |v| * 10 < 2^FRAC_BITS
    localparam logic [HEAD_W-1:0] STOP_MAX = HEAD_W'(((1 << FRAC_BITS) - 1) / 10);

    // move step: |target - head| / MOVE_STEPS by reciprocal, exact below 2^MOVE_IN_W
    localparam int MOVE_IN_W   = HEAD_W + 1;
    localparam int MOVE_SHIFT  = MOVE_IN_W + $clog2(MOVE_STEPS);
    localparam longint MOVE_RECIP =
        ((longint'(1) << MOVE_SHIFT) + MOVE_STEPS - 1) / MOVE_STEPS;
    localparam int MOVE_PROD_W = MOVE_SHIFT + HEAD_W;

    // decay: 4*|v| / 5 by reciprocal
    localparam int DECAY_DIV    = 5;
    localparam int DECAY_IN_W   = HEAD_W + 2;
    localparam int DECAY_SHIFT  = DECAY_IN_W + $clog2(DECAY_DIV);
    localparam longint DECAY_RECIP =
        ((longint'(1) << DECAY_SHIFT) + DECAY_DIV - 1) / DECAY_DIV;
    localparam int DECAY_PROD_W = DECAY_SHIFT + HEAD_W;

    localparam logic signed [WIDE_W-1:0] HEAD_MAX_W = 26'sd8388607;
    localparam logic signed [WIDE_W-1:0] HEAD_MIN_W = -26'sd8388608;

    localparam logic [OP_W-1:0] OP_SET     = 3'd0;
    localparam logic [OP_W-1:0] OP_SCROLL  = 3'd1;
    localparam logic [OP_W-1:0] OP_MOVE    = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUBBER   = 2'd2;

    localparam logic [CODE_W-1:0] MOTION_IDLE   = 2'd0;
    localparam logic [CODE_W-1:0] MOTION_MOVE   = 2'd1;
    localparam logic [CODE_W-1:0] MOTION_BOUNCE = 2'd2;
    localparam logic [CODE_W-1:0] MOTION_COAST  = 2'd3;

    typedef enum logic [2:0] {
        CMD_SET, CMD_SCROLL, CMD_MOVE, CMD_RELEASE, CMD_TICK, CMD_NOP
    } cmd_kind_t;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_MOVE   = 4'b0010,
        MODE_BOUNCE = 4'b0100,
        MODE_COAST  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [CFG_W-1:0] viewport;
        logic [CFG_W-1:0] content;
        logic             rubber;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic signed [VAL_W-1:0] value;
        logic signed [HEAD_W-1:0] set_head;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic signed [WIDE_W-1:0] widen(input logic signed [HEAD_W-1:0] x);
        return {{(WIDE_W - HEAD_W){x[HEAD_W-1]}}, x};
    endfunction

    function automatic logic signed [WIDE_W-1:0] widen_u(input logic [CFG_W-1:0] x);
        return {{(WIDE_W - CFG_W){1'b0}}, x};
    endfunction

    function automatic logic signed [HEAD_W-1:0] sat24(input logic signed [WIDE_W-1:0] x);
        if (x > HEAD_MAX_W) begin
            return HEAD_MAX_W[HEAD_W-1:0];
        end else if (x < HEAD_MIN_W) begin
            return HEAD_MIN_W[HEAD_W-1:0];
        end
        return x[HEAD_W-1:0];
    endfunction

    // round(x / 2^n), half away from zero; elaboration use only
    function automatic longint shr_round(input longint x, input int n);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (longint'(1) << (n - 1))) >>> n;
        return (x < 0) ? -mag : mag;
    endfunction

    // cos(0.3 * k) in Q2.14 from the Q30 Chebyshev recurrence
    function automatic logic signed [COS_W-1:0] cos_entry(input int k);
        longint prev;
        longint cur;
        longint nxt;
        prev = longint'(1) << 30;
        cur  = COS_STEP_Q30;
        if (k == 0) begin
            return COS_W'(shr_round(prev, 16));
        end
        for (int i = 1; i < k; i++) begin
            nxt  = shr_round(COS_STEP_Q30 * cur, 29) - prev;
            prev = cur;
            cur  = nxt;
        end
        return COS_W'(shr_round(cur, 16));
    endfunction

    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        case (m)
            MODE_IDLE:   return MOTION_IDLE;
            MODE_MOVE:   return MOTION_MOVE;
            MODE_BOUNCE: return MOTION_BOUNCE;
            MODE_COAST:  return MOTION_COAST;
            default:     return MOTION_IDLE;
        endcase
    endfunction

endpackage

FILE: design/ksp_front.sv
// ksp_front: accepts input events, classifies the operation and pre-clamps the
// set-head position against the current configuration. Depends on ksp_pkg.
module ksp_front (
    input  ksp_pkg::cfg_t                      cfg,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ksp_pkg::OP_W-1:0]           s_operation,
    input  logic signed [ksp_pkg::VAL_W-1:0]   s_value,
    input  ksp_pkg::q_stat_t                   q_stat,
    output logic                               push,
    output ksp_pkg::cmd_t                      cmd
);
    import ksp_pkg::*;

    logic signed [WIDE_W-1:0] lo_w;
    logic signed [WIDE_W-1:0] set_w;

    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready;

    // set head only depends on the configuration, so it is resolved here
    always_comb begin
        lo_w  = widen_u(cfg.viewport) - widen_u(cfg.content);
        set_w = widen(s_value);
        if (set_w < lo_w) begin
            set_w = lo_w;
        end
        if (set_w > 26'sd0) begin
            set_w = 26'sd0;
        end
    end

    always_comb begin
        cmd.value    = s_value;
        cmd.set_head = set_w[HEAD_W-1:0];
        case (s_operation)
            OP_SET:     cmd.kind = CMD_SET;
            OP_SCROLL:  cmd.kind = CMD_SCROLL;
            OP_MOVE:    cmd.kind = CMD_MOVE;
            OP_RELEASE: cmd.kind = CMD_RELEASE;
            OP_TICK:    cmd.kind = CMD_TICK;
            default:    cmd.kind = CMD_NOP;
        endcase
    end

endmodule

FILE: design/ksp_queue.sv
// ksp_queue: short command queue between the front and the back.
// Depends on ksp_pkg for the command struct and depth constants.
module ksp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ksp_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output ksp_pkg::cmd_t    head_cmd,
    output ksp_pkg::q_stat_t q_stat
);
    import ksp_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_stat.empty = (count_reg == QCNT_W'(0));
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_cmd     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: design/ksp_back.sv
// ksp_back: executes one queued command per cycle when not stalled, against the scroll state
// (head, velocity, bounce edge, phase, steps, mode) and holds the result register.
// Depends on ksp_pkg for types, fixed-point helpers and the cosine table.
module ksp_back #(
    parameter int COS_TABLE_DEPTH = ksp_pkg::COS_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ksp_pkg::cfg_t                     cfg,
    input  ksp_pkg::q_stat_t                  q_stat,
    input  ksp_pkg::cmd_t                     cmd,
    output logic                              pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ksp_pkg::HEAD_W-1:0] m_head_position,
    output logic                              m_animating,
    output logic [ksp_pkg::CODE_W-1:0]        m_motion_mode
);
    import ksp_pkg::*;

    localparam int PHASE_W = $clog2(COS_TABLE_DEPTH);
    localparam int PROD_W  = HEAD_W + COS_W;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(COS_TABLE_DEPTH - 1);
    localparam logic [MOVE_PROD_W-1:0]  MOVE_RECIP_V  = MOVE_PROD_W'(MOVE_RECIP);
    localparam logic [DECAY_PROD_W-1:0] DECAY_RECIP_V = DECAY_PROD_W'(DECAY_RECIP);

    logic signed [COS_W-1:0] cos_rom [COS_TABLE_DEPTH];

    for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_cos
        assign cos_rom[g] = cos_entry(g);
    end

    logic signed [HEAD_W-1:0] head_reg,  head_next;
    logic signed [HEAD_W-1:0] vel_reg,   vel_next;
    logic signed [HEAD_W-1:0] bounce_edge_reg, bounce_edge_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [STEP_W-1:0]        steps_reg, steps_next;
    mode_t                    mode_reg,  mode_next;

    logic                     out_valid_reg;
    logic signed [HEAD_W-1:0] out_head_reg;
    logic                     out_anim_reg;
    logic [CODE_W-1:0]        out_code_reg;
    logic                     anim;

    logic signed [WIDE_W-1:0] lo_w;
    logic signed [WIDE_W-1:0] head_w;
    logic                     cs_gt_vp;

    logic signed [COS_W-1:0]  cos_val;
    logic signed [PROD_W-1:0] bounce_prod;
    logic [PROD_W-1:0]        bounce_mag;
    logic [PROD_W-1:0]        bounce_rnd;
    logic [WIDE_W-1:0]        bounce_q;
    logic signed [WIDE_W-1:0] bounce_off;
    logic signed [HEAD_W-1:0] bounce_head;

    logic [HEAD_W-1:0]        vel_mag;
    logic [DECAY_PROD_W-1:0]  decay_prod;
    logic [HEAD_W-1:0]        decay_q;
    logic signed [HEAD_W-1:0] vel_decay;
    logic                     decay_stop;

    logic signed [WIDE_W-1:0] diff_w;
    logic [WIDE_W-1:0]        diff_mag;
    logic [MOVE_PROD_W-1:0]   move_prod;
    logic [HEAD_W-1:0]        move_q;
    logic signed [HEAD_W-1:0] move_vel;

    logic signed [HEAD_W-1:0] scroll_head;
    logic signed [HEAD_W-1:0] drift_head;
    logic [STEP_W-1:0]        steps_dec;

    assign pop = !q_stat.empty && (!out_valid_reg || m_ready);

    assign lo_w     = widen_u(cfg.viewport) - widen_u(cfg.content);
    assign head_w   = widen(head_reg);
    assign cs_gt_vp = cfg.content > cfg.viewport;

    // bounce: edge + round(v * cos / 2^14), half away from zero
    assign cos_val     = cos_rom[phase_reg];
    assign bounce_prod = $signed(vel_reg) * $signed(cos_val);
    assign bounce_mag  = bounce_prod[PROD_W-1] ? PROD_W'(0) - bounce_prod : bounce_prod;
    assign bounce_rnd  = bounce_mag + (PROD_W'(1) << (COS_FRAC - 1));
    assign bounce_q    = bounce_rnd[COS_FRAC +: WIDE_W];
    assign bounce_off  = bounce_prod[PROD_W-1] ? WIDE_W'(0) - bounce_q : bounce_q;
    assign bounce_head = sat24(widen(bounce_edge_reg) + bounce_off);

    // decay: 4|v|/5 truncated, sign restored
    assign vel_mag    = vel_reg[HEAD_W-1] ? HEAD_W'(0) - vel_reg : vel_reg;
    assign decay_prod = DECAY_PROD_W'({vel_mag, 2'b00}) * DECAY_RECIP_V;
    assign decay_q    = decay_prod[DECAY_SHIFT +: HEAD_W];
    assign vel_decay  = vel_reg[HEAD_W-1] ? HEAD_W'(0) - decay_q : decay_q;
    assign decay_stop = decay_q <= STOP_MAX;

    // move step: (target - head) / MOVE_STEPS toward zero
    assign diff_w    = widen(cmd.value) - head_w;
    assign diff_mag  = diff_w[WIDE_W-1] ? WIDE_W'(0) - diff_w : diff_w;
    assign move_prod = MOVE_PROD_W'(diff_mag[MOVE_IN_W-1:0]) * MOVE_RECIP_V;
    assign move_q    = move_prod[MOVE_SHIFT +: HEAD_W];
    assign move_vel  = diff_w[WIDE_W-1] ? HEAD_W'(0) - move_q : move_q;

    assign drift_head = sat24(head_w + widen(vel_reg));
    assign steps_dec  = steps_reg - STEP_W'(1);

    always_comb begin
        scroll_head = sat24(head_w + widen(cmd.value));
        if (!cfg.rubber) begin
            if (scroll_head > 24'sd0) begin
                scroll_head = '0;
            end
            if (widen(scroll_head) < lo_w) begin
                scroll_head = cs_gt_vp ? lo_w[HEAD_W-1:0] : '0;
            end
        end
    end

    always_comb begin
        head_next        = head_reg;
        vel_next         = vel_reg;
        bounce_edge_next = bounce_edge_reg;
        phase_next       = phase_reg;
        steps_next       = steps_reg;
        mode_next        = mode_reg;
        anim             = 1'b0;
        case (cmd.kind)
            CMD_SET: begin
                head_next = cmd.set_head;
            end
            CMD_SCROLL: begin
                mode_next = MODE_IDLE;
                head_next = scroll_head;
                vel_next  = cmd.value;
            end
            CMD_MOVE: begin
                if (cfg.rubber) begin
                    vel_next   = move_vel;
                    mode_next  = MODE_MOVE;
                    steps_next = STEP_W'(MOVE_STEPS);
                end
            end
            CMD_RELEASE: begin
                if (cfg.rubber) begin
                    if (head_reg > 24'sd0) begin
                        vel_next         = head_reg;
                        bounce_edge_next = '0;
                        phase_next       = '0;
                        mode_next        = MODE_BOUNCE;
                    end else if (head_w < lo_w) begin
                        if (cs_gt_vp) begin
                            vel_next         = HEAD_W'(head_w - lo_w);
                            bounce_edge_next = lo_w[HEAD_W-1:0];
                        end else begin
                            vel_next         = head_reg;
                            bounce_edge_next = '0;
                        end
                        phase_next = '0;
                        mode_next  = MODE_BOUNCE;
                    end else begin
                        mode_next = MODE_COAST;
                    end
                end
            end
            CMD_TICK: begin
                case (mode_reg)
                    MODE_BOUNCE: begin
                        head_next = bounce_head;
                        vel_next  = vel_decay;
                        if (phase_reg < PHASE_LAST) begin
                            phase_next = phase_reg + PHASE_W'(1);
                        end
                        if (decay_stop) begin
                            mode_next = MODE_IDLE;
                        end
                        anim = 1'b1;
                    end
                    MODE_COAST: begin
                        head_next = drift_head;
                        vel_next  = vel_decay;
                        if (decay_stop) begin
                            mode_next = MODE_IDLE;
                        end else begin
                            anim = 1'b1;
                        end
                    end
                    MODE_MOVE: begin
                        head_next  = drift_head;
                        steps_next = steps_dec;
                        if (steps_dec == STEP_W'(0)) begin
                            mode_next = MODE_IDLE;
                        end
                        anim = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg        <= '0;
            vel_reg         <= '0;
            bounce_edge_reg <= '0;
            phase_reg       <= '0;
            steps_reg       <= '0;
            mode_reg        <= MODE_IDLE;
            out_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                head_reg        <= head_next;
                vel_reg         <= vel_next;
                bounce_edge_reg <= bounce_edge_next;
                phase_reg       <= phase_next;
                steps_reg       <= steps_next;
                mode_reg        <= mode_next;
                out_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_head_reg <= head_next;
            out_anim_reg <= anim;
            out_code_reg <= mode_code(mode_next);
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_head_position = out_head_reg;
    assign m_animating     = out_anim_reg;
    assign m_motion_mode   = out_code_reg;

endmodule

FILE: design/kinetic_scroll_position_engine.sv
// kinetic_scroll_position_engine: top level; configuration registers, front
// classifier, command queue and execution back end. Depends on ksp_pkg,
// ksp_front, ksp_queue and ksp_back.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_operation, s_value
//  m_        out        m_valid / m_ready      m_head_position, m_animating, m_motion_mode
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one event per cycle while m_ready is high; an event is queued, then registered at the output
// the back end applies one command per cycle unless the output stalls, in a single state update loop
// synchronous active-low reset clears queue pointers, output valid, configuration and scroll state
// with m_ready low the output register holds, the two-entry queue fills, then s_ready drops
// cfg_ready is always high
module kinetic_scroll_position_engine #(
    parameter int COS_TABLE_DEPTH = ksp_pkg::COS_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ksp_pkg::OP_W-1:0]            s_operation,
    input  logic signed [ksp_pkg::VAL_W-1:0]    s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ksp_pkg::HEAD_W-1:0]   m_head_position,
    output logic                                m_animating,
    output logic [ksp_pkg::CODE_W-1:0]          m_motion_mode,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ksp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ksp_pkg::CFG_W-1:0]           cfg_data
);
    import ksp_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    front_cmd;
    cmd_t    head_cmd;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_VIEWPORT: cfg_reg.viewport <= cfg_data;
                CFG_CONTENT:  cfg_reg.content  <= cfg_data;
                CFG_RUBBER:   cfg_reg.rubber   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ksp_front u_front (
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value     (s_value),
        .q_stat      (q_stat),
        .push        (push),
        .cmd         (front_cmd)
    );

    ksp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    ksp_back #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_stat          (q_stat),
        .cmd             (head_cmd),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_head_position (m_head_position),
        .m_animating     (m_animating),
        .m_motion_mode   (m_motion_mode)
    );

`ifndef SYNTHESIS
    // only a tick can report motion
    a_anim_only_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && (head_cmd.kind != CMD_TICK) |=> !m_animating)
        else $error("animating set for a non-tick transaction");

    // an accepted transaction is queued on the next cycle
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !q_stat.empty)
        else $error("accepted transaction missing from queue");

    a_reset_clears: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid && q_stat.empty)
        else $error("output or queue not cleared by reset");
`endif

endmodule

FILE: verif/tb_kinetic_scroll_position_engine.sv
`timescale 1ns / 100ps
// tb_kinetic_scroll_position_engine: self-checking bench for the kinetic scroll engine;
// an in-bench predictor tracks head, velocity and motion mode for each accepted event.
// Depends on ksp_pkg and kinetic_scroll_position_engine.
module tb_kinetic_scroll_position_engine;
    import ksp_pkg::*;

    localparam int COS_DEPTH = COS_DEPTH_DEFAULT;
    localparam int PHASE_W   = $clog2(COS_DEPTH);
    localparam int PIXEL     = 1 << FRAC_BITS;

    localparam logic [OP_W-1:0]         OP_CODE_MAX = {OP_W{1'b1}};
    localparam logic [CFG_W-1:0]        CFG_MAX     = {CFG_W{1'b1}};
    localparam logic signed [VAL_W-1:0] VAL_MAX     = {1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN     = {1'b1, {(VAL_W - 1){1'b0}}};

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
    } scroll_event_t;

    typedef struct packed {
        logic signed [HEAD_W-1:0] head;
        logic                     animating;
        logic [CODE_W-1:0]        mode;
    } head_report_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [OP_W-1:0]            s_operation = '0;
    logic signed [VAL_W-1:0]    s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [HEAD_W-1:0]   m_head_position;
    logic                       m_animating;
    logic [CODE_W-1:0]          m_motion_mode;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;

    kinetic_scroll_position_engine dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_head_position (m_head_position),
        .m_animating     (m_animating),
        .m_motion_mode   (m_motion_mode),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #4 aclk = ~aclk;

    // predictor copy of the engine
    logic [CFG_W-1:0]         viewport_q = '0;
    logic [CFG_W-1:0]         content_q = '0;
    logic                     rubber_q = 1'b0;
    logic signed [HEAD_W-1:0] head_q = '0;
    logic signed [HEAD_W-1:0] vel_q = '0;
    logic signed [HEAD_W-1:0] rest_q = '0;
    logic [PHASE_W-1:0]       phase_q = '0;
    logic [STEP_W-1:0]        steps_q = '0;
    logic [CODE_W-1:0]        motion_q = MOTION_IDLE;
    logic signed [COS_W-1:0]  cos_q14 [COS_DEPTH];

    scroll_event_t pending_q[$];
    head_report_t  expected_q[$];
    scroll_event_t ev;
    head_report_t  want;
    bit            calm = 1'b0;
    int            errors = 0;
    int            issued = 0;
    int            results_seen = 0;
    int            rx_hold_left = 0;

    // round half away from zero
    function automatic longint round_shift(input longint x, input int n);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (longint'(1) << (n - 1))) >>> n;
        return (x < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp24(input longint x);
        if (x > longint'(VAL_MAX)) return longint'(VAL_MAX);
        if (x < longint'(VAL_MIN)) return longint'(VAL_MIN);
        return x;
    endfunction

    function automatic longint decay(input longint v);
        return (v < 0) ? -(((-v) * 4) / 5) : (v * 4) / 5;
    endfunction

    function automatic bit too_slow(input longint v);
        return ((v < 0) ? -v : v) * 10 < (longint'(1) << FRAC_BITS);
    endfunction

    // cos(0.3 k) in q2.14 via chebyshev recurrence in q30
    function automatic void build_cos_table();
        longint prev;
        longint cur;
        longint nxt;
        prev = longint'(1) << 30;
        cur  = COS_STEP_Q30;
        cos_q14[0] = COS_W'(round_shift(prev, 16));
        for (int i = 1; i < COS_DEPTH; i++) begin
            cos_q14[i] = COS_W'(round_shift(cur, 16));
            nxt  = round_shift(COS_STEP_Q30 * cur, 29) - prev;
            prev = cur;
            cur  = nxt;
        end
    endfunction

    function automatic head_report_t predict_scroll(input logic [OP_W-1:0] op,
                                                    input logic signed [VAL_W-1:0] value);
        longint       vp;
        longint       cs;
        longint       h;
        longint       v;
        logic         anim;
        head_report_t r;
        vp   = viewport_q;
        cs   = content_q;
        h    = head_q;
        v    = vel_q;
        anim = 1'b0;
        case (op)
            OP_SET: begin
                h = value;
                if (h + cs < vp) h = vp - cs;
                if (h > 0) h = 0;
            end
            OP_SCROLL: begin
                motion_q = MOTION_IDLE;
                h = clamp24(h + value);
                v = value;
                if (!rubber_q) begin
                    if (h > 0) h = 0;
                    if (h + cs < vp) h = (cs > vp) ? vp - cs : 0;
                end
            end
            OP_MOVE: begin
                if (rubber_q) begin
                    v = (longint'(value) - h) / MOVE_STEPS;
                    motion_q = MOTION_MOVE;
                    steps_q = STEP_W'(MOVE_STEPS);
                end
            end
            OP_RELEASE: begin
                if (rubber_q) begin
                    if (h > 0) begin
                        v = h;
                        rest_q = '0;
                        phase_q = '0;
                        motion_q = MOTION_BOUNCE;
                    end else if (h + cs < vp) begin
                        // bounce to the bottom edge, or to zero when content fits the view
                        if (cs > vp) begin
                            v = h + cs - vp;
                            rest_q = HEAD_W'(vp - cs);
                        end else begin
                            v = h;
                            rest_q = '0;
                        end
                        phase_q = '0;
                        motion_q = MOTION_BOUNCE;
                    end else begin
                        motion_q = MOTION_COAST;
                    end
                end
            end
            OP_TICK: begin
                case (motion_q)
                    MOTION_BOUNCE: begin
                        h = clamp24(longint'(rest_q) +
                                    round_shift(v * longint'(cos_q14[phase_q]), COS_FRAC));
                        v = decay(v);
                        if (phase_q < COS_DEPTH - 1) phase_q = phase_q + 1'b1;
                        if (too_slow(v)) motion_q = MOTION_IDLE;
                        anim = 1'b1;
                    end
                    MOTION_COAST: begin
                        h = clamp24(h + v);
                        v = decay(v);
                        if (too_slow(v)) motion_q = MOTION_IDLE;
                        else anim = 1'b1;
                    end
                    MOTION_MOVE: begin
                        h = clamp24(h + v);
                        steps_q = steps_q - 1'b1;
                        if (steps_q == '0) motion_q = MOTION_IDLE;
                        anim = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        head_q = h[HEAD_W-1:0];
        vel_q  = v[HEAD_W-1:0];
        r = '{head: head_q, animating: anim, mode: motion_q};
        return r;
    endfunction

    // event driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_scroll(s_operation, s_value));
            end
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
                    ev = pending_q.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= ev.op;
                    s_value     <= ev.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                // long back-pressure so the engine fills and stalls its input
                if (results_seen % 200 == 100) rx_hold_left = 80;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected transaction, head %0d animating %0d mode %0d",
                             $time, m_head_position, m_animating, m_motion_mode);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_head_position !== want.head) begin
                        $display("%0t: head_position expected %0d got %0d",
                                 $time, want.head, m_head_position);
                        errors++;
                    end
                    if (m_animating !== want.animating) begin
                        $display("%0t: animating expected %0d got %0d",
                                 $time, want.animating, m_animating);
                        errors++;
                    end
                    if (m_motion_mode !== want.mode) begin
                        $display("%0t: motion_mode expected %0d got %0d",
                                 $time, want.mode, m_motion_mode);
                        errors++;
                    end
                end
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || $urandom_range(0, 99) >= 9;
            end
        end
    end

    task automatic add_event(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] value);
        pending_q.push_back('{op: op, value: value});
        issued++;
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_event(OP_TICK, VAL_W'($urandom));
    endtask

    function automatic logic signed [VAL_W-1:0] any_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VAL_W'($urandom_range(0, 8191)) - VAL_W'(4096);
            4, 5, 6: return VAL_W'($urandom_range(0, 2048 * PIXEL)) - VAL_W'(1024 * PIXEL);
            7: return VAL_MAX;
            8: return VAL_MIN;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic add_gesture();
        int                      n;
        logic signed [VAL_W-1:0] big;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                // drag then fling
                n = $urandom_range(1, 4);
                repeat (n) add_event(OP_SCROLL, any_value());
                add_event(OP_RELEASE, VAL_W'($urandom));
                add_ticks($urandom_range(3, 60));
            end
            4, 5: begin
                add_event(OP_MOVE, any_value());
                add_ticks($urandom_range(8, 14));
            end
            6: begin
                // pull past an edge and let it bounce back
                big = VAL_W'($urandom_range(PIXEL, VAL_MAX));
                add_event(OP_SCROLL, $urandom_range(0, 1) ? big : -big);
                add_event(OP_RELEASE, VAL_W'($urandom));
                add_ticks($urandom_range(10, 60));
            end
            7: add_event(OP_SET, any_value());
            default: begin
                n = $urandom_range(1, 4);
                repeat (n) add_event(OP_W'($urandom_range(0, OP_CODE_MAX)), VAL_W'($urandom));
            end
        endcase
    endtask

    task automatic random_phase(input int n);
        int start;
        start = issued;
        while (issued - start < n) add_gesture();
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_q.size() != 0 || s_valid || expected_q.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_VIEWPORT: viewport_q = data;
            CFG_CONTENT:  content_q = data;
            default:      rubber_q = data[0];
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] vp, input logic [CFG_W-1:0] cs,
                             input logic rub);
        write_reg(CFG_VIEWPORT, vp);
        write_reg(CFG_CONTENT, cs);
        write_reg(CFG_RUBBER, CFG_W'(rub));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] vp_r;
        build_cos_table();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: empty view, rubber banding off, moves and releases ignored
        add_event(OP_TICK, '0);
        add_event(OP_SET, VAL_MAX);
        add_event(OP_SET, VAL_MIN);
        add_event(OP_SCROLL, VAL_MAX);
        add_event(OP_SCROLL, VAL_MIN);
        add_event(OP_MOVE, VAL_MIN);
        add_event(OP_RELEASE, VAL_MAX);
        add_event(OP_TICK + 3'd1, VAL_MAX);
        add_event(OP_CODE_MAX - 3'd1, '0);
        add_event(OP_CODE_MAX, VAL_MIN);
        wait_drained();

        configure(CFG_W'(200 * PIXEL), CFG_W'(2000 * PIXEL), 1'b1);
        add_event(OP_SET, VAL_MIN);
        add_event(OP_SCROLL, VAL_MIN);
        add_event(OP_RELEASE, '0);
        add_ticks(2);
        add_event(OP_SET, '0);
        add_event(OP_SCROLL, VAL_W'(10 * PIXEL));
        add_event(OP_RELEASE, '0);
        add_ticks(2);
        add_event(OP_MOVE, -VAL_W'(100 * PIXEL));
        add_ticks(2);
        add_event(OP_SCROLL, -VAL_W'(PIXEL));
        add_event(OP_RELEASE, '0);
        add_ticks(2);
        random_phase(50);
        wait_drained();

        configure(CFG_MAX, CFG_MAX, 1'b1);
        random_phase(50);
        wait_drained();

        // content no longer than the view, no idling on either side
        calm = 1'b1;
        vp_r = CFG_W'($urandom);
        configure(vp_r, CFG_W'($urandom_range(0, vp_r)), 1'b1);
        random_phase(50);
        wait_drained();
        calm = 1'b0;

        configure('0, CFG_MAX, 1'b0);
        random_phase(50);
        wait_drained();

        configure(CFG_W'($urandom), CFG_W'($urandom), 1'b1);
        random_phase(25);
        wait_drained();
        random_phase(25);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
